// File: design/assert_macros.svh
// Assertion macros used by the core of the reply parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/jlrp_pkg.sv
// Types, constants and helper functions of the reply parser.
package jlrp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] chan_t;

	localparam byte_t CHAR_COMMA  = 8'h2C;
	localparam byte_t CHAR_ZERO   = 8'h30;
	localparam byte_t CHAR_NINE   = 8'h39;
	localparam int    HEAD_LEN    = 6;
	localparam logic [3:0] COMMA_RED   = 4'd3;
	localparam logic [3:0] COMMA_GREEN = 4'd6;
	localparam logic [3:0] COMMA_BLUE  = 4'd9;
	localparam logic [3:0] COMMA_MAX   = 4'd15;
	localparam logic [3:0] COMMA_NEED  = 4'd6;
	localparam chan_t CH_RED   = 2'd0;
	localparam chan_t CH_GREEN = 2'd1;
	localparam chan_t CH_BLUE  = 2'd2;
	localparam int    NUM_CH   = 3;
	// Smallest parsed value whose scaled level reaches full scale.
	localparam logic signed [15:0] CLAMP_FROM = 16'sd102;

	// Status of one capture window for the current byte.
	typedef struct packed {
		logic  fin_hit;    // window completes on its fourth byte
		chan_t fin_ch;
		byte_t fin_level;
		logic  busy;       // still capturing after this byte
		logic  end_hit;    // window cut off by the end of the message
		chan_t end_ch;
		byte_t end_level;
	} jlrp_win_t;

	// Expected opening characters of a reply, by position.
	function automatic byte_t head_char(input logic [2:0] pos);
		byte_t c;
		case (pos)
			3'd0: c = 8'h7B;   // {
			3'd1: c = 8'h22;   // "
			3'd2: c = 8'h69;   // i
			3'd3: c = 8'h64;   // d
			3'd4: c = 8'h22;   // "
			3'd5: c = 8'h3A;   // :
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input byte_t b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

	// Level = trunc(2.5 * v) clamped to 0..255, where
	// v = (h-48)*100 + (t-48)*10 (+ (u-48) when u is a digit and used).
	function automatic byte_t level_of(input byte_t h, input byte_t t,
			input logic use_u, input byte_t u);
		logic signed [15:0] hv;
		logic signed [15:0] tv;
		logic signed [15:0] uv;
		logic signed [15:0] v;
		logic [8:0] s;
		byte_t lvl;
		hv = $signed({8'd0, h}) - 16'sd48;
		tv = $signed({8'd0, t}) - 16'sd48;
		uv = (use_u && is_digit(u)) ? ($signed({8'd0, u}) - 16'sd48) : 16'sd0;
		v  = hv * 16'sd100 + tv * 16'sd10 + uv;
		s  = 9'((v[8:0] * 9'd5) >> 1);
		if (v <= 16'sd0) begin
			lvl = 8'd0;
		end else if (v >= CLAMP_FROM) begin
			lvl = 8'hFF;
		end else begin
			lvl = s[7:0];
		end
		return lvl;
	endfunction

endpackage

// File: design/jlrp_window.sv
// One four-byte capture window that turns a d.dd field into a colour level.
module jlrp_window
	import jlrp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,       // a byte is processed this cycle
	input  byte_t     data_byte,
	input  logic      last,
	input  logic      start,      // open the window after this byte
	input  chan_t     start_ch,
	output jlrp_win_t status
);

	logic       active_q;
	logic [2:0] pos_q;
	chan_t      ch_q;
	byte_t      hund_q;
	byte_t      tens_q;

	logic [2:0] pos_inc;
	byte_t      hund_n;
	byte_t      tens_n;
	logic       fin;
	logic       busy;

	// Capture the hundreds and tens bytes and detect completion.
	always_comb begin
		pos_inc = pos_q + 3'd1;
		hund_n  = hund_q;
		tens_n  = tens_q;
		fin     = 1'b0;
		if (active_q) begin
			case (pos_inc)
				3'd1: hund_n = data_byte;
				3'd3: tens_n = data_byte;
				3'd4: fin = 1'b1;
				default: ;
			endcase
		end
		busy = active_q && !fin;
		if (start) begin
			hund_n = CHAR_ZERO;
			tens_n = CHAR_ZERO;
		end
	end

	// Report completion and the cut-off level seen at the end of a message.
	always_comb begin
		status.fin_hit   = fin;
		status.fin_ch    = ch_q;
		status.fin_level = level_of(hund_q, tens_q, 1'b1, data_byte);
		status.busy      = busy;
		status.end_hit   = last && (busy || start);
		status.end_ch    = start ? start_ch : ch_q;
		status.end_level = level_of(hund_n, tens_n, 1'b0, data_byte);
	end

	// Window control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= 3'd0;
		end else if (step) begin
			if (last) begin
				active_q <= 1'b0;
				pos_q    <= 3'd0;
			end else begin
				active_q <= busy || start;
				pos_q    <= (start || fin) ? 3'd0 : pos_inc;
			end
		end
	end

	// Captured bytes and channel.
	always_ff @(posedge clk) begin
		if (step) begin
			hund_q <= hund_n;
			tens_q <= tens_n;
			if (start) begin
				ch_q <= start_ch;
			end
		end
	end

endmodule

// File: design/json_light_reply_rgb_parser_core.sv
// Top level of the reply parser: byte stream in, one verdict per message out.
//
// Usage:
//  - Slave stream: one message byte per transfer in s_axis_tdata, s_axis_tlast
//    marks the final byte of the message.
//  - Master stream: one result transfer per message, issued for the final byte.
//    It carries accepted, show_led and the red, green and blue levels.
//  - cfg_we/cfg_wdata write min_parse_length; write it only between messages.
//  - Throughput is one byte per cycle while a final byte finds the result
//    register free. Each byte is taken into an input register, from which a
//    short single pass of compare, count and level logic updates the message
//    state and, on the final byte, loads the result register.
//  - The result is registered; the receiver takes it from the result register.
//  - When the receiver stalls, the result register holds its result; one more
//    byte can still be taken and non-final bytes keep flowing. A final byte
//    waits in the input register until the result register is free.
//  - Reset clears the message state, empties both registers and sets
//    min_parse_length to 120.
module json_light_reply_rgb_parser_core
	import jlrp_pkg::*;
#(
	parameter int MAX_MSG_LEN = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [0] accepted, [1] show_led, [9:2] red,
	                                    // [17:10] green, [25:18] blue, [31:26] zero
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata       // min_parse_length
);

	`include "assert_macros.svh"

	localparam byte_t MAX_LEN = 8'(MAX_MSG_LEN);

	// Input register and handshake.
	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;
	logic  adv;
	logic  out_valid_q;

	// Message state.
	byte_t      min_len_q;
	byte_t      count_q;
	logic       prefix_q;
	logic [3:0] comma_q;
	byte_t      level_q [NUM_CH];

	// Next state.
	byte_t      count_n;
	logic       prefix_n;
	logic [3:0] comma_n;
	byte_t      level_n [NUM_CH];
	logic       trigger;
	chan_t      trig_ch;
	logic       start0;
	logic       start1;
	logic       step_last;
	jlrp_win_t  win0;
	jlrp_win_t  win1;

	// Result fields.
	logic  res_acc;
	logic  res_show;
	byte_t res_r;
	byte_t res_g;
	byte_t res_b;
	logic [25:0] out_data_q;

	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign step_last     = last_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Prefix check, byte count and comma count.
	always_comb begin
		prefix_n = prefix_q;
		if ((count_q < 8'(HEAD_LEN)) && (data_s1 != head_char(count_q[2:0]))) begin
			prefix_n = 1'b0;
		end
		count_n = (count_q < MAX_LEN) ? count_q + 8'd1 : count_q;
		comma_n = comma_q;
		if ((data_s1 == CHAR_COMMA) && (comma_q < COMMA_MAX)) begin
			comma_n = comma_q + 4'd1;
		end
	end

	// A colour field follows commas three, six and nine.
	always_comb begin
		trigger = 1'b0;
		trig_ch = CH_RED;
		if (data_s1 == CHAR_COMMA) begin
			case (comma_n)
				COMMA_RED: begin
					trigger = 1'b1;
					trig_ch = CH_RED;
				end
				COMMA_GREEN: begin
					trigger = 1'b1;
					trig_ch = CH_GREEN;
				end
				COMMA_BLUE: begin
					trigger = 1'b1;
					trig_ch = CH_BLUE;
				end
				default: ;
			endcase
		end
		start0 = trigger && !win0.busy;
		start1 = trigger && win0.busy && !win1.busy;
	end

	jlrp_window u_win0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (data_s1),
		.last      (step_last),
		.start     (start0),
		.start_ch  (trig_ch),
		.status    (win0)
	);

	jlrp_window u_win1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (data_s1),
		.last      (step_last),
		.start     (start1),
		.start_ch  (trig_ch),
		.status    (win1)
	);

	// Level updates: completed windows first, then windows cut off at the end.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			level_n[c] = level_q[c];
			if (win0.fin_hit && (win0.fin_ch == chan_t'(c))) begin
				level_n[c] = win0.fin_level;
			end
			if (win1.fin_hit && (win1.fin_ch == chan_t'(c))) begin
				level_n[c] = win1.fin_level;
			end
			if (win0.end_hit && (win0.end_ch == chan_t'(c))) begin
				level_n[c] = win0.end_level;
			end
			if (win1.end_hit && (win1.end_ch == chan_t'(c))) begin
				level_n[c] = win1.end_level;
			end
		end
	end

	// Verdict for a message that ends with this byte.
	always_comb begin
		res_acc  = 1'b0;
		res_show = 1'b0;
		if (prefix_n && (count_n >= 8'(HEAD_LEN))) begin
			if (count_n < min_len_q) begin
				res_acc = 1'b1;
			end else if (comma_n >= COMMA_NEED) begin
				res_acc  = 1'b1;
				res_show = 1'b1;
			end
		end
		res_r = res_show ? level_n[CH_RED]   : 8'd0;
		res_g = res_show ? level_n[CH_GREEN] : 8'd0;
		res_b = res_show ? level_n[CH_BLUE]  : 8'd0;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= 8'd120;
		end else if (cfg_we) begin
			min_len_q <= cfg_wdata;
		end
	end

	// Message state, cleared after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 8'd0;
			prefix_q <= 1'b1;
			comma_q  <= 4'd0;
			for (int c = 0; c < NUM_CH; c++) begin
				level_q[c] <= 8'd0;
			end
		end else if (adv) begin
			if (last_s1) begin
				count_q  <= 8'd0;
				prefix_q <= 1'b1;
				comma_q  <= 4'd0;
				for (int c = 0; c < NUM_CH; c++) begin
					level_q[c] <= 8'd0;
				end
			end else begin
				count_q  <= count_n;
				prefix_q <= prefix_n;
				comma_q  <= comma_n;
				for (int c = 0; c < NUM_CH; c++) begin
					level_q[c] <= level_n[c];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_data_q <= {res_b, res_g, res_r, res_show, res_acc};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_data_q};

	`CHECK_NOW(a_show_implies_acc, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0],
		"LED update reported for a rejected message")
	`CHECK_NOW(a_dark_when_no_show, m_axis_tvalid && !m_axis_tdata[1],
		m_axis_tdata[25:2] == 24'd0, "colour levels present without LED update")
	`CHECK_NEXT(a_clear_after_last, adv && last_s1,
		(count_q == 8'd0) && (comma_q == 4'd0) && prefix_q,
		"message state not cleared after the final byte")
	`CHECK_NEXT(a_result_loaded, adv && last_s1, out_valid_q,
		"final byte did not produce a result")
	`CHECK_NOW(a_single_start, 1'b1, !(start0 && start1),
		"two capture windows opened by one comma")

endmodule

// File: test/tb_json_light_reply_rgb_parser_core.sv
// Self-checking testbench for the reply parser core: directed and random messages.
module tb_json_light_reply_rgb_parser_core
	import jlrp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Verdict of one message, laid out as it travels in m_axis_tdata.
	typedef struct packed {
		logic [5:0] pad;
		byte_t      blue;
		byte_t      green;
		byte_t      red;
		logic       show;
		logic       acc;
	} verdict_t;

	// One capture window of the colour parser.
	typedef struct {
		bit          active;
		int unsigned pos;
		chan_t       ch;
		byte_t       hund;
		byte_t       tens;
	} capture_t;

	localparam int       NO_CFG      = -1;
	localparam int       MSG_LEN_MAX = 255;
	localparam int       RANDOM_BYTES = 800;
	localparam verdict_t REJECT      = 32'h0;
	localparam verdict_t ACC_ONLY    = 32'h1;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;     // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;            // [0] accepted, [1] show_led, [9:2] red,
	                                      // [17:10] green, [25:18] blue, [31:26] zero
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;       // min_parse_length

	json_light_reply_rgb_parser_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// Opening characters every reply must start with.
	byte_t opening [HEAD_LEN] = '{8'h7B, 8'h22, 8'h69, 8'h64, 8'h22, 8'h3A};

	// Parser state mirrored by the predictor.
	byte_t    min_len = 8'd120;
	byte_t    msg_len = 8'd0;
	bit       head_ok = 1'b1;
	logic [3:0] commas = 4'd0;
	byte_t    level [NUM_CH];
	capture_t win [2];

	verdict_t verdict_q [$];
	byte_t    msg_buf [$];
	int       errors = 0;
	int       burst_left = 0;
	int       random_bytes = 0;

	// Receiver stall pattern state.
	int       rx_mode = 0;
	int       rx_left = 0;

	// Directed messages, with a typed verdict where it is obvious.
	localparam int DIR_ROWS = 14;
	int dir_cfg [DIR_ROWS] = '{NO_CFG, NO_CFG, NO_CFG, NO_CFG, NO_CFG, 0, NO_CFG,
		NO_CFG, NO_CFG, NO_CFG, 255, 7, NO_CFG, NO_CFG};
	string dir_msg [DIR_ROWS] = '{
		"{\"id\":",                                 // shortest good reply
		"{\"id\"",                                  // too short for the opening
		"[\"id\":,,,,,,",                           // wrong first character
		"\377",                                     // one byte, all ones
		"{\"id\":,,,1.00,,,0.50,,,0.25",            // below the default length
		"{\"id\":1,a,b,1.00,c,d,0.50,e,f,0.25}",    // well-formed colour reply
		"{\"id\":1,2,3,4,5",                        // only four commas
		"{\"id\":,,,-.00,,,9.99,,,0.4x",            // negative, large, non-digit units
		"{\"id\":,,,1.5,,,2.,,,3",                  // windows cut by commas and the end
		"{\"id\":,,,,,,1.23,,,4.56",                // green window opens inside red's
		"{\"id\":,,,,,,,,,,,,,,,,,,,,,,,,,,",       // comma count saturates, too short
		"{\"id\":",                                 // just below a threshold of seven
		"{\"id\":,,,,,,",                           // six commas, nothing captured
		"{\"id\":,,,,,,,,,,,,,,,,,,,,,"             // saturated commas, parsed
	};
	bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 0, 1, 0, 0, 0, 1, 1, 0, 0};
	verdict_t dir_want [DIR_ROWS] = '{ACC_ONLY, REJECT, REJECT, REJECT, ACC_ONLY,
		REJECT, REJECT, REJECT, REJECT, REJECT, ACC_ONLY, ACC_ONLY, REJECT, REJECT};

	// Level of one channel: 2.5 times the parsed d.dd value in hundredths, clamped to a byte.
	function automatic byte_t scaled_level(input byte_t h, input byte_t t,
			input bit use_u, input byte_t u);
		int v;
		int s;
		v = (int'(h) - 48) * 100 + (int'(t) - 48) * 10;
		if (use_u && u >= CHAR_ZERO && u <= CHAR_NINE)
			v += int'(u) - 48;
		if (v <= 0)
			return 8'd0;
		s = (5 * v) / 2;
		return (s > 255) ? 8'hFF : byte_t'(s);
	endfunction

	function automatic void clear_message();
		msg_len = 8'd0;
		head_ok = 1'b1;
		commas = 4'd0;
		for (int i = 0; i < NUM_CH; i++)
			level[i] = 8'd0;
		for (int i = 0; i < 2; i++)
			win[i] = '{1'b0, 0, CH_RED, 8'd0, 8'd0};
	endfunction

	// Advance the parser by one byte; on the final byte produce the verdict.
	task automatic parse_byte(input byte_t b, input logic is_last, output bit got,
			output verdict_t r);
		bit opened;
		got = 1'b0;
		r = REJECT;
		opened = 1'b0;
		if (msg_len < HEAD_LEN && b != opening[msg_len])
			head_ok = 1'b0;

		// Capture windows take the byte at their next position.
		for (int i = 0; i < 2; i++) begin
			if (win[i].active) begin
				win[i].pos++;
				if (win[i].pos == 1) begin
					win[i].hund = b;
				end else if (win[i].pos == 3) begin
					win[i].tens = b;
				end else if (win[i].pos >= 4) begin
					level[win[i].ch] = scaled_level(win[i].hund, win[i].tens, 1'b1, b);
					win[i].active = 1'b0;
					win[i].pos = 0;
				end
			end
		end

		// Commas 3, 6 and 9 open a window on the first free slot.
		if (b == CHAR_COMMA) begin
			if (commas < COMMA_MAX)
				commas++;
			if (commas == COMMA_RED || commas == COMMA_GREEN || commas == COMMA_BLUE) begin
				for (int i = 0; i < 2; i++) begin
					if (!win[i].active && !opened) begin
						win[i] = '{1'b1, 0, chan_t'(commas / 3 - 1), CHAR_ZERO, CHAR_ZERO};
						opened = 1'b1;
					end
				end
			end
		end

		if (msg_len < MSG_LEN_MAX)
			msg_len++;

		if (is_last) begin
			for (int i = 0; i < 2; i++) begin
				if (win[i].active)
					level[win[i].ch] = scaled_level(win[i].hund, win[i].tens, 1'b0, 8'd0);
			end
			if (head_ok && msg_len >= HEAD_LEN) begin
				if (msg_len < min_len) begin
					r = ACC_ONLY;
				end else if (commas >= COMMA_NEED) begin
					r.acc = 1'b1;
					r.show = 1'b1;
					r.red = level[CH_RED];
					r.green = level[CH_GREEN];
					r.blue = level[CH_BLUE];
				end
			end
			got = 1'b1;
			clear_message();
		end
	endtask

	task automatic report(input string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	// Send one byte in bursts with random gaps, then predict on its transfer.
	task automatic push_byte(input byte_t b, input logic is_last, input bit typed,
			input verdict_t want);
		bit got;
		verdict_t r;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		parse_byte(b, is_last, got, r);
		if (got)
			verdict_q.push_back(typed ? want : r);
	endtask

	// Change the length threshold once the block has gone quiet.
	task automatic set_min_len(input byte_t v);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_len = v;
	endtask

	task automatic add_filler(input int n);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0: msg_buf.push_back(byte_t'($urandom_range(0, 255)));
				1, 2: msg_buf.push_back(byte_t'(CHAR_ZERO + $urandom_range(0, 9)));
				default: msg_buf.push_back(byte_t'(8'h61 + $urandom_range(0, 25)));
			endcase
		end
	endtask

	// A d.dd value, mostly plausible, now and then with a stray byte in it.
	task automatic add_value();
		byte_t v [4];
		v[0] = byte_t'(CHAR_ZERO + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 9)
			: $urandom_range(0, 2)));
		v[1] = 8'h2E;
		v[2] = byte_t'(CHAR_ZERO + $urandom_range(0, 9));
		v[3] = byte_t'(CHAR_ZERO + $urandom_range(0, 9));
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 7) == 0)
				v[i] = byte_t'($urandom_range(0, 255));
			msg_buf.push_back(v[i]);
		end
	endtask

	// Build one random message: mostly well-formed replies, some noise and damage.
	task automatic build_msg(input bit long_one);
		int kind;
		int ncomma;
		int n;
		msg_buf.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) msg_buf.push_back(byte_t'($urandom_range(0, 255)));
		end else begin
			for (int i = 0; i < HEAD_LEN; i++)
				msg_buf.push_back(opening[i]);
			if (kind == 1)
				msg_buf[$urandom_range(0, HEAD_LEN - 1)] = byte_t'($urandom_range(0, 255));
			if (long_one)
				add_filler(250);
			ncomma = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(6, 10);
			for (int c = 1; c <= ncomma; c++) begin
				add_filler($urandom_range(0, 3));
				msg_buf.push_back(CHAR_COMMA);
				if (c % 3 == 0 && c <= 9 && $urandom_range(0, 4) != 0)
					add_value();
			end
			add_filler($urandom_range(0, 4));
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, msg_buf.size());
				while (msg_buf.size() > n)
					void'(msg_buf.pop_back());
			end
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls follow a mode that is drawn anew whenever its countdown runs out.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (rx_left % 3 == 0);
			default: m_axis_tready <= (rx_left < 8);
		endcase
	end

	// Compare every result transfer with the oldest expected verdict.
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (verdict_q.size() == 0) begin
				report($sformatf("unexpected result %h", got));
			end else begin
				want = verdict_q.pop_front();
				if (got.acc !== want.acc)
					report($sformatf("accepted %b, want %b", got.acc, want.acc));
				if (got.show !== want.show)
					report($sformatf("show_led %b, want %b", got.show, want.show));
				if (got.red !== want.red)
					report($sformatf("red %0d, want %0d", got.red, want.red));
				if (got.green !== want.green)
					report($sformatf("green %0d, want %0d", got.green, want.green));
				if (got.blue !== want.blue)
					report($sformatf("blue %0d, want %0d", got.blue, want.blue));
				if (got.pad !== 6'd0)
					report($sformatf("upper bits %b, want zero", got.pad));
			end
		end
	end

	// Run limit.
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// Stimulus: reset, the directed table, then random messages.
	initial begin
		int msg_no;
		int len;
		clear_message();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_ROWS; k++) begin
			if (dir_cfg[k] != NO_CFG)
				set_min_len(byte_t'(dir_cfg[k]));
			len = dir_msg[k].len();
			for (int j = 0; j < len; j++)
				push_byte(dir_msg[k][j], j == len - 1, dir_typed[k], dir_want[k]);
		end

		msg_no = 0;
		while (random_bytes < RANDOM_BYTES) begin
			if (msg_no % 10 == 0) begin
				case ($urandom_range(0, 5))
					0: set_min_len(8'd0);
					1: set_min_len(8'd255);
					2: set_min_len(8'd120);
					3: set_min_len(8'd6);
					default: set_min_len(byte_t'($urandom_range(0, 80)));
				endcase
			end
			build_msg(msg_no % 12 == 3);
			for (int j = 0; j < msg_buf.size(); j++)
				push_byte(msg_buf[j], j == msg_buf.size() - 1, 1'b0, REJECT);
			random_bytes += msg_buf.size();
			msg_no++;
		end

		// Drain and let the pipeline settle.
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/jlrp_pkg.sv
design/jlrp_window.sv
design/json_light_reply_rgb_parser_core.sv
test/tb_json_light_reply_rgb_parser_core.sv
